[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define LAD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define LAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LAD_ASSERT(lbl, ante, cons, msg)
`define LAD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/lad_pkg.sv]
// ----------------------------------------------------------------------------
// Layer area anomaly detector package
// Item types, register codes and fixed field widths.
// ----------------------------------------------------------------------------
package lad_pkg;

    localparam int IN_AREA_W   = 32;
    localparam int OUT_AREA_W  = 32;
    localparam int OFFSET_W    = 12;
    localparam int THR_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_SHIFT = 9;   // thresholds are Q4.8, the average is sum/2
    localparam int QUEUE_DEPTH = 4;   // power of two

    localparam logic [THR_W-1:0] DROP_RESET    = 12'd128;
    localparam logic [THR_W-1:0] RISE_RESET    = 12'd512;
    localparam logic [THR_W-1:0] SIMILAR_RESET = 12'd51;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP    = 2'd0,
        CFG_RISE    = 2'd1,
        CFG_SIMILAR = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [IN_AREA_W-1:0] area_sample;
        logic                        last_layer;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_W-1:0]          layer_offset;
        logic                         flagged;
        logic                         is_rise;
        logic                         repair_ok;
        logic                         copy_from_prev;
        logic signed [OUT_AREA_W-1:0] measured_area;
        logic signed [OUT_AREA_W-1:0] neighbor_average;
    } t_out_item;

endpackage

[sv/lad_ifs.sv]
// ----------------------------------------------------------------------------
// Layer area anomaly detector channels
// Valid/ready interfaces for the sample, result and register write channels.
// ----------------------------------------------------------------------------
interface lad_in_if import lad_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lad_out_if import lad_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lad_cfg_if import lad_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/lad_front.sv]
// ----------------------------------------------------------------------------
// Layer area anomaly detector front end
// Keeps the per-object window, forms neighbour sums and gaps, queues a job.
// ----------------------------------------------------------------------------
module lad_front import lad_pkg::*; #(
    parameter int AREA_WIDTH = 32,
    parameter int MAX_LAYERS = 4096,
    localparam int JOB_W     = 3 * AREA_WIDTH + OFFSET_W + 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lad_in_if.sink           i_in,
    input  logic             i_full,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job
);

    localparam int LW = $clog2(MAX_LAYERS);
    localparam int SW = AREA_WIDTH + 1;
    localparam int RW = (AREA_WIDTH > IN_AREA_W) ? AREA_WIDTH : IN_AREA_W;

    typedef struct packed {
        logic [OFFSET_W-1:0]          offset;
        logic signed [AREA_WIDTH-1:0] value;
        logic signed [AREA_WIDTH:0]   sum;
        logic [AREA_WIDTH:0]          gap;
        logic                         from_prev;
    } t_job;

    logic [LW-1:0]                r_seen, n_seen;
    logic signed [AREA_WIDTH-1:0] r_older, n_older;
    logic signed [AREA_WIDTH-1:0] r_middle, n_middle;
    logic [RW-1:0]                raw;
    logic signed [AREA_WIDTH-1:0] sample;
    logic                         accept;
    logic                         emit;
    logic signed [SW-1:0]         d_pn, d_pv, d_nv;
    logic [SW-1:0]                a_pn, a_pv, a_nv;
    t_job                         job;

    // The sign is taken from the top bit of the configured area width.
    assign raw    = RW'($unsigned(i_in.data.area_sample));
    assign sample = $signed(raw[AREA_WIDTH-1:0]);

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign emit       = (r_seen >= LW'(2));
    assign o_push     = accept && emit;

    always_comb begin
        d_pn = SW'(r_older) - SW'(sample);
        d_pv = SW'(r_older) - SW'(r_middle);
        d_nv = SW'(sample) - SW'(r_middle);
        a_pn = $unsigned(d_pn[AREA_WIDTH] ? -d_pn : d_pn);
        a_pv = $unsigned(d_pv[AREA_WIDTH] ? -d_pv : d_pv);
        a_nv = $unsigned(d_nv[AREA_WIDTH] ? -d_nv : d_nv);

        job.offset    = OFFSET_W'(r_seen - LW'(1));
        job.value     = r_middle;
        job.sum       = SW'(r_older) + SW'(sample);
        job.gap       = a_pn;
        job.from_prev = (a_pv <= a_nv);
    end

    assign o_job = job;

    always_comb begin
        n_seen   = r_seen;
        n_older  = r_older;
        n_middle = r_middle;
        if (accept) begin
            if (i_in.data.last_layer) begin
                n_seen   = '0;
                n_older  = '0;
                n_middle = '0;
            end else begin
                n_older  = r_middle;
                n_middle = sample;
                if (r_seen != LW'(MAX_LAYERS - 1)) begin
                    n_seen = r_seen + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_older  <= '0;
            r_middle <= '0;
        end else begin
            r_seen   <= n_seen;
            r_older  <= n_older;
            r_middle <= n_middle;
        end
    end

endmodule

[sv/lad_queue.sv]
// ----------------------------------------------------------------------------
// Layer area anomaly detector job queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lad_queue import lad_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = PW + 1;

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + PW'(1) : r_wr;
        n_rd    = i_pop ? r_rd + PW'(1) : r_rd;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `LAD_ASSERT(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH), "queue count above depth")
    `LAD_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "queue count did not rise")
    `LAD_ASSERT_NEXT(a_count_down, i_pop && !i_push, r_count == $past(r_count) - CW'(1), "queue count did not fall")

endmodule

[sv/lad_back.sv]
// ----------------------------------------------------------------------------
// Layer area anomaly detector back end
// Holds the thresholds, forms the cross products, judges and registers results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lad_back import lad_pkg::*; #(
    parameter int AREA_WIDTH = 32,
    localparam int JOB_W     = 3 * AREA_WIDTH + OFFSET_W + 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lad_cfg_if.sink          i_cfg,
    input  logic             i_valid,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_pop,
    lad_out_if.source        o_out
);

    localparam int SW  = AREA_WIDTH + 1;
    localparam int PRW = AREA_WIDTH + THR_W + 2;
    localparam int XW  = 64;

    typedef struct packed {
        logic [OFFSET_W-1:0]          offset;
        logic signed [AREA_WIDTH-1:0] value;
        logic signed [AREA_WIDTH:0]   sum;
        logic [AREA_WIDTH:0]          gap;
        logic                         from_prev;
    } t_job;

    t_job                   job;
    logic [THR_W-1:0]       r_drop, r_rise, r_similar;
    logic                   s2_free, s1_free;
    logic signed [PRW-1:0]  value_ext;
    logic signed [SW-1:0]   rounded;
    logic signed [SW-1:0]   half;
    logic signed [XW-1:0]   value_wide, avg_wide;

    logic                   r_s1_valid;
    logic signed [PRW-1:0]  r_drop_prod, r_rise_prod, r_sim_prod;
    logic signed [PRW-1:0]  r_scaled, r_gap_scaled;
    logic                   r_sum_pos;
    logic                   r_from_prev;
    logic [OFFSET_W-1:0]    r_offset;
    logic [OUT_AREA_W-1:0]  r_value32, r_avg32;

    logic                   is_drop, is_up, flag;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;

    assign job = i_job;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop    <= DROP_RESET;
            r_rise    <= RISE_RESET;
            r_similar <= SIMILAR_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_DROP:    r_drop    <= i_cfg.data;
                CFG_RISE:    r_rise    <= i_cfg.data;
                CFG_SIMILAR: r_similar <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage flow: the output register frees stage one, stage one frees the queue.
    assign s2_free = !r_out_valid || o_out.ready;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_pop   = i_valid && s1_free;

    // The average truncates toward zero, so negative sums are bumped first.
    always_comb begin
        value_ext  = PRW'(job.value);
        rounded    = job.sum + $signed(SW'(job.sum[AREA_WIDTH]));
        half       = rounded >>> 1;
        value_wide = XW'(job.value);
        avg_wide   = XW'(half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_drop_prod  <= PRW'($signed({1'b0, r_drop})) * PRW'(job.sum);
            r_rise_prod  <= PRW'($signed({1'b0, r_rise})) * PRW'(job.sum);
            r_sim_prod   <= PRW'($signed({1'b0, r_similar})) * PRW'(job.sum);
            r_scaled     <= value_ext <<< SCALE_SHIFT;
            r_gap_scaled <= $signed(PRW'({job.gap, {SCALE_SHIFT{1'b0}}}));
            r_sum_pos    <= !job.sum[AREA_WIDTH] && (job.sum != '0);
            r_from_prev  <= job.from_prev;
            r_offset     <= job.offset;
            r_value32    <= value_wide[OUT_AREA_W-1:0];
            r_avg32      <= avg_wide[OUT_AREA_W-1:0];
        end
    end

    // Judgement: with a positive sum the ratio tests become plain compares.
    always_comb begin
        is_drop = (r_scaled < r_drop_prod);
        is_up   = (r_scaled > r_rise_prod);
        flag    = r_sum_pos && (is_drop || is_up);

        n_out.layer_offset     = r_offset;
        n_out.flagged          = flag;
        n_out.is_rise          = flag && !is_drop;
        n_out.repair_ok        = flag && (r_gap_scaled <= r_sim_prod);
        n_out.copy_from_prev   = flag && r_from_prev;
        n_out.measured_area    = $signed(r_value32);
        n_out.neighbor_average = $signed(r_avg32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `LAD_ASSERT(a_unflagged_quiet, r_out_valid && !r_out.flagged, !r_out.is_rise && !r_out.repair_ok && !r_out.copy_from_prev, "unflagged result carries flags")
    `LAD_ASSERT_NEXT(a_stall_keeps, r_out_valid && !o_out.ready, r_out_valid, "result dropped while stalled")
    `LAD_ASSERT_NEXT(a_stage_moves, r_s1_valid && s2_free, r_out_valid, "stage one item did not reach output")

endmodule

[sv/layer_area_anomaly_detector.sv]
// ----------------------------------------------------------------------------
// Layer area anomaly detector
// i_in carries one layer area (signed Q23.8) and a last-layer mark per item.
// From the third layer of an object on, each item judges the layer before it
// against its two neighbours and yields one result on o_out; the first two
// items of an object and the layer after a last-layer mark yield none.
// i_cfg writes the drop, rise and similarity thresholds (Q4.8) by index;
// writes to unused indices are dropped. Write only while the block is idle.
// Throughput: one item per cycle while the job queue is not full. A result
// becomes valid once its job has entered the queue at the accepting edge and
// has passed the cross-product stage and the output register.
// The front end stalls only when the four-entry job queue is full, so a
// stalled receiver holds o_out steady and backs up into i_in after the queue
// and both back-end stages fill. Synchronous reset clears the window, the
// queue and all pipeline valids, and loads the threshold reset values.
// ----------------------------------------------------------------------------
module layer_area_anomaly_detector import lad_pkg::*; #(
    parameter int MAX_LAYERS = 4096,
    parameter int AREA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lad_in_if.sink     i_in,
    lad_out_if.source  o_out,
    lad_cfg_if.sink    i_cfg
);

    localparam int JOB_W = 3 * AREA_WIDTH + OFFSET_W + 3;

    logic             push;
    logic             full;
    logic             pop;
    logic             job_valid;
    logic [JOB_W-1:0] push_job;
    logic [JOB_W-1:0] pop_job;

    lad_front #(
        .AREA_WIDTH (AREA_WIDTH),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    lad_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (pop_job)
    );

    lad_back #(
        .AREA_WIDTH (AREA_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_valid (job_valid),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
